[hdl/hpla_pkg.sv]
package hpla_pkg;

  // Default number of wing cells; the tip cell sits one past the last of them.
  localparam int WING_CELLS_DEF = 24;

  // Stream widths: fields packed from bit 0 and padded to whole bytes.
  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  // Tick queue between the front and back halves.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Animation constants.
  localparam logic [7:0]  DECAY_MUL   = 8'hF0;   // 240/256 cooling per tick
  localparam logic [5:0]  BOOST_REST  = 6'd16;   // 1.0 in 2.4
  localparam logic [5:0]  BOOST_KICK  = 6'd32;   // 2.0 in 2.4 after a wing pass
  localparam logic [11:0] FULL_CHARGE = 12'hFFF;
  localparam logic [8:0]  BASE_STEP   = 9'd32;   // fixed part of charge and travel steps
  localparam logic [14:0] TRAVEL_HALF = 15'd128; // rounding of the 6.8 travel position
  localparam logic [7:0]  HEAT_MAX    = 8'hFF;
  localparam logic [7:0]  BUMP_NEAR   = 8'd63;   // full charge >> 6
  localparam logic [7:0]  BUMP_FAR    = 8'd15;   // full charge >> 8
  localparam logic [10:0] BRIGHT_MIN  = 11'd32;
  localparam logic [7:0]  FLOOR_DIM   = 8'd16;
  localparam logic [7:0]  FLOOR_FULL  = 8'd63;
  localparam logic [13:0] DRIVE_ROUND = 14'd8;

  // One tick after the front has pre-scaled its channels.
  typedef struct packed {
    logic [8:0] chg_inc;  // charge step: 32 + throttle/8
    logic [8:0] tp_inc;   // travel step: 32 + rounded throttle/8
    logic [7:0] bright;   // brightness/8, zero below the dead band
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_APPLY,
    ST_EMIT
  } state_t;

endpackage

[hdl/hpla_front.sv]
module hpla_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [hpla_pkg::IN_W-1:0] in_tdata,
  output logic                      q_valid,
  input  logic                      q_pop,
  output hpla_pkg::item_t           q_item
);

  hpla_pkg::item_t                   mem_r [hpla_pkg::QUEUE_DEPTH];
  logic [hpla_pkg::QPTR_W-1:0]       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [hpla_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic [10:0]                       thr, brt;
  logic [11:0]                       thr_rnd;
  hpla_pkg::item_t                   item_w;
  logic                              push;

  localparam logic [hpla_pkg::QPTR_W-1:0] PTR_LAST = hpla_pkg::QPTR_W'(hpla_pkg::QUEUE_DEPTH - 1);
  localparam logic [hpla_pkg::QCNT_W-1:0] CNT_FULL = hpla_pkg::QCNT_W'(hpla_pkg::QUEUE_DEPTH);

  // classify: pre-scale both channels so the back end only adds
  always_comb begin
    thr = in_tdata[10:0];
    brt = in_tdata[21:11];
    thr_rnd = 12'(thr) + 12'd4;
    item_w.chg_inc = hpla_pkg::BASE_STEP + {1'b0, thr[10:3]};
    item_w.tp_inc  = hpla_pkg::BASE_STEP + 9'(thr_rnd[11:3]);
    item_w.bright  = (brt < hpla_pkg::BRIGHT_MIN) ? 8'd0 : brt[10:3];
  end

  assign in_tready = (cnt_r != CNT_FULL);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
    end
    if (q_pop) begin
      rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= item_w;
    end
  end

endmodule

[hdl/hpla_back.sv]
module hpla_back #(
  parameter int WING_CELLS = hpla_pkg::WING_CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       q_valid,
  input  hpla_pkg::item_t            q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hpla_pkg::OUT_W-1:0] out_tdata,
  output logic                       out_tlast
);

  localparam int CELLS = WING_CELLS + 1;
  localparam int TIP   = WING_CELLS;
  localparam int CNT_W = $clog2(WING_CELLS);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WING_CELLS - 1);
  localparam logic [6:0]       LAST_CELL = 7'(WING_CELLS - 1);

  hpla_pkg::state_t state_r, state_nxt;
  hpla_pkg::item_t  item_r;
  logic             dim_r;
  logic [11:0]      charge_r, charge_nxt;
  logic [13:0]      tp_r, tp_nxt;
  logic [5:0]       boost_r, boost_nxt;
  logic             full_r, wrap_r;
  logic [11:0]      cval_r;
  logic [6:0]       prev_r, idx_r;
  logic [7:0]       drive_r;
  logic [7:0]       heat_r [CELLS];
  logic [7:0]       heat_nxt [CELLS];
  logic [CNT_W-1:0] cnt_r;
  logic             ld_beat;

  logic             out_valid_r, out_last_r;
  logic [4:0]       out_idx_r;
  logic [7:0]       out_heat_r, out_tip_r, out_drive_r;

  // tick scalar update
  logic [12:0] c_sum;
  logic        c_full, c_wrap;
  logic [6:0]  prev_w, idx_w;
  logic [13:0] tp_sum;
  logic [14:0] prev_ext, idx_ext;
  logic [5:0]  excess, relaxed;
  logic [9:0]  down_ext;

  // drive
  logic [7:0]  bsel, bfloor, bmax;
  logic [13:0] dprod;
  logic [9:0]  dscaled;
  logic [7:0]  drive_w;

  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? hpla_pkg::HEAT_MAX : s[7:0];
  endfunction

  // Per-cell heat update of one tick; tip flash is applied by the caller.
  function automatic logic [7:0] cell_next(input logic [7:0] h, input logic [7:0] pos,
                                           input logic full, input logic [11:0] cval,
                                           input logic [6:0] prev, input logic [6:0] idx);
    logic [15:0] prod;
    logic [7:0]  d, add, idx8;
    logic [7:0]  r;
    prod = 16'(h) * 16'(hpla_pkg::DECAY_MUL);
    d    = prod[15:8];
    idx8 = {1'b0, idx};
    add  = 8'd0;
    r    = d;
    if (!full) begin
      if (pos == 8'd2) begin
        add = cval[11:4];
      end else if (pos == 8'd1 || pos == 8'd3) begin
        add = {2'b0, cval[11:6]};
      end else if (pos == 8'd0 || pos == 8'd4) begin
        add = {4'b0, cval[11:8]};
      end
      r = sat_add(d, add);
    end else if (pos >= {1'b0, prev} && pos <= idx8 + 8'd2) begin
      r = hpla_pkg::HEAT_MAX;
    end else begin
      if (pos == idx8 + 8'd3) begin
        add = hpla_pkg::BUMP_NEAR;
      end else if (pos == idx8 + 8'd4) begin
        add = hpla_pkg::BUMP_FAR;
      end
      r = sat_add(d, add);
    end
    return r;
  endfunction

  always_comb begin
    c_sum    = 13'(charge_r) + 13'(item_r.chg_inc);
    c_full   = (c_sum >= 13'(hpla_pkg::FULL_CHARGE));
    prev_ext = 15'(tp_r) + hpla_pkg::TRAVEL_HALF;
    prev_w   = prev_ext[14:8];
    tp_sum   = tp_r + 14'(item_r.tp_inc);
    idx_ext  = 15'(tp_sum) + hpla_pkg::TRAVEL_HALF;
    idx_w    = idx_ext[14:8];
    c_wrap   = c_full && (idx_w > LAST_CELL);

    // boost eases back toward 1.0: falls by ceil, rises by floor
    excess   = boost_r - hpla_pkg::BOOST_REST;
    down_ext = {excess, 4'b0} + 10'd255;
    if (boost_r > hpla_pkg::BOOST_REST) begin
      relaxed = boost_r - 6'(down_ext[9:8]);
    end else begin
      relaxed = boost_r + ((hpla_pkg::BOOST_REST - boost_r) >> 4);
    end

    charge_nxt = charge_r;
    tp_nxt     = tp_r;
    boost_nxt  = boost_r;
    if (state_r == hpla_pkg::ST_CALC) begin
      boost_nxt = c_wrap ? hpla_pkg::BOOST_KICK : relaxed;
      if (!c_full) begin
        charge_nxt = c_sum[11:0];
      end else if (c_wrap) begin
        charge_nxt = '0;
        tp_nxt     = '0;
      end else begin
        charge_nxt = hpla_pkg::FULL_CHARGE;
        tp_nxt     = tp_sum;
      end
    end
  end

  always_comb begin
    bsel    = dim_r ? {2'b0, item_r.bright[7:2]} : item_r.bright;
    bfloor  = dim_r ? hpla_pkg::FLOOR_DIM : hpla_pkg::FLOOR_FULL;
    bmax    = (bsel < bfloor) ? bfloor : bsel;
    dprod   = 14'(bmax) * 14'(boost_r) + hpla_pkg::DRIVE_ROUND;
    dscaled = dprod[13:4];
    drive_w = (dscaled > 10'd255) ? 8'hFF : dscaled[7:0];
  end

  // heat store: parallel update on apply, rotate wing cells as beats leave
  always_comb begin
    for (int i = 0; i < CELLS; i++) begin
      heat_nxt[i] = heat_r[i];
    end
    if (state_r == hpla_pkg::ST_APPLY) begin
      for (int i = 0; i < CELLS; i++) begin
        heat_nxt[i] = cell_next(heat_r[i], 8'(i), full_r, cval_r, prev_r, idx_r);
      end
      if (wrap_r) begin
        heat_nxt[TIP] = hpla_pkg::HEAT_MAX;
      end
    end else if (ld_beat) begin
      for (int i = 0; i < WING_CELLS - 1; i++) begin
        heat_nxt[i] = heat_r[i + 1];
      end
      heat_nxt[WING_CELLS - 1] = heat_r[0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    ld_beat   = 1'b0;
    unique case (state_r)
      hpla_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = hpla_pkg::ST_CALC;
        end
      end
      hpla_pkg::ST_CALC: begin
        state_nxt = hpla_pkg::ST_APPLY;
      end
      hpla_pkg::ST_APPLY: begin
        state_nxt = hpla_pkg::ST_EMIT;
      end
      hpla_pkg::ST_EMIT: begin
        ld_beat = !out_valid_r || out_tready;
        if (ld_beat && cnt_r == CNT_LAST) begin
          state_nxt = hpla_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = hpla_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpla_pkg::ST_IDLE;
      dim_r       <= 1'b0;
      charge_r    <= '0;
      tp_r        <= '0;
      boost_r     <= hpla_pkg::BOOST_REST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CELLS; i++) begin
        heat_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      charge_r <= charge_nxt;
      tp_r     <= tp_nxt;
      boost_r  <= boost_nxt;
      for (int i = 0; i < CELLS; i++) begin
        heat_r[i] <= heat_nxt[i];
      end
      if (cfg_wr_en) begin
        dim_r <= cfg_wr_data;
      end
      if (state_r == hpla_pkg::ST_APPLY) begin
        cnt_r <= '0;
      end else if (ld_beat) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ld_beat) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
    end
    if (state_r == hpla_pkg::ST_CALC) begin
      full_r <= c_full;
      wrap_r <= c_wrap;
      cval_r <= c_sum[11:0];
      prev_r <= prev_w;
      idx_r  <= idx_w;
    end
    if (state_r == hpla_pkg::ST_APPLY) begin
      drive_r <= drive_w;
    end
    if (ld_beat) begin
      out_idx_r   <= 5'(cnt_r);
      out_heat_r  <= heat_r[0];
      out_tip_r   <= heat_r[TIP];
      out_drive_r <= drive_r;
      out_last_r  <= (cnt_r == CNT_LAST);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b0, out_drive_r, out_tip_r, out_heat_r, out_idx_r};

  a_boost_range: assert property (@(posedge clk) disable iff (!rst_n)
    boost_r <= hpla_pkg::BOOST_KICK)
    else $error("boost above kick level");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hpla_pkg::ST_EMIT |-> cnt_r <= CNT_LAST)
    else $error("beat counter past last wing cell");

  a_apply_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hpla_pkg::ST_APPLY |=> state_r == hpla_pkg::ST_EMIT && cnt_r == '0)
    else $error("emit did not start at cell 0 after apply");

  a_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[4:0] == 5'(WING_CELLS - 1))
    else $error("tlast on a beat other than the last wing cell");

endmodule

[hdl/heat_pulse_led_animator.sv]
// Heat-pulse LED animator. Each input beat is one frame tick (throttle,
// brightness); each tick produces WING_CELLS output beats, cell 0 first, each
// carrying that cell's heat, the tip flash heat and the floodlight drive, with
// tlast on the final cell. In the back end a tick is taken off the queue,
// then the charge/travel/boost update runs, then the parallel heat-store
// update, then its beats leave one per cycle through the single output
// register while out_tready stays high. A two-entry tick queue sits in front,
// so up to two further ticks are taken while a tick is being emitted. The heat
// store resets to zero; no clearing pass is needed. dim_level (cfg_wr_data) is
// to be written with cfg_wr_en only while the block is idle; the user must keep
// to this, the block itself does not enforce it.
module heat_pulse_led_animator #(
  parameter int WING_CELLS = hpla_pkg::WING_CELLS_DEF  // 8..32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // config: dim_level
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  // ticks
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [hpla_pkg::IN_W-1:0]  in_tdata,   // throttle[10:0], brightness[21:11]
  // per-cell results
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [hpla_pkg::OUT_W-1:0] out_tdata,  // cell_index[4:0], cell_heat[12:5],
                                                 // tip_heat[20:13], drive_level[28:21]
  output logic                       out_tlast
);

  logic            q_valid;
  logic            q_pop;
  hpla_pkg::item_t q_item;

  // front: takes tick beats, pre-scales channels, queues them
  hpla_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // back: state update, heat store, per-cell beats
  hpla_back #(
    .WING_CELLS (WING_CELLS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

[sim/hpla_beat_checker.sv]
// Watches the config port and both streams, keeps its own model of the
// animation state and checks every output beat against the next expected one.
module hpla_beat_checker #(
  parameter int CELLS = hpla_pkg::WING_CELLS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [hpla_pkg::IN_W-1:0]  in_tdata,   // throttle[10:0], brightness[21:11]
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [hpla_pkg::OUT_W-1:0] out_tdata,  // cell_index[4:0], cell_heat[12:5],
                                                 // tip_heat[20:13], drive_level[28:21]
  input  logic                       out_tlast,
  output int                         n_bad,
  output int                         n_due
);

  localparam int unsigned CHARGE_FULL = 'hFFF;

  typedef struct packed {
    logic [4:0] idx;
    logic [7:0] heat;
    logic [7:0] tip;
    logic [7:0] drive;
    logic       last;
  } cell_beat_t;

  cell_beat_t  cell_beats_due[$];
  logic [7:0]  heat [0:CELLS];   // wing cells plus the tip cell
  logic [11:0] charge;
  logic [13:0] travel;           // 6.8 position along the wing
  logic [5:0]  boost;            // 2.4
  logic        dim;

  // saturating add; anything aimed past the tip cell is dropped
  task automatic heat_bump(input int unsigned idx, input int unsigned add);
    int unsigned v;
    if (idx <= CELLS) begin
      v = int'(heat[idx]) + add;
      heat[idx] = (v > 255) ? 8'hFF : v[7:0];
    end
  endtask

  task automatic advance_heat_tick(input int unsigned thr, input int unsigned brt);
    int unsigned c;
    int unsigned prev_pos;
    int unsigned pos;
    int unsigned b;
    int unsigned flr;
    int unsigned drv;
    cell_beat_t  e;
    for (int i = 0; i <= CELLS; i++)
      heat[i] = 8'((int'(heat[i]) * 240) >> 8);

    if (boost > 16)
      boost = 6'(int'(boost) - (((int'(boost) - 16) * 16 + 255) >> 8));
    else
      boost = 6'(int'(boost) + (((16 - int'(boost)) * 16) >> 8));

    c = int'(charge) + 32 + ((thr * 32) >> 8);
    if (c < CHARGE_FULL) begin
      // still charging: heat builds around the start cells
      charge = c[11:0];
      heat_bump(2, c >> 4);
      heat_bump(1, c >> 6);
      heat_bump(3, c >> 6);
      heat_bump(0, c >> 8);
      heat_bump(4, c >> 8);
    end else begin
      charge   = CHARGE_FULL[11:0];
      prev_pos = (int'(travel) + 128) >> 8;
      c        = int'(travel) + 32 + ((thr * 32 + 128) >> 8);
      travel   = c[13:0];
      pos      = (int'(travel) + 128) >> 8;
      for (int unsigned i = prev_pos; i <= pos + 2 && i <= CELLS; i++)
        heat[i] = 8'hFF;
      heat_bump(pos + 3, CHARGE_FULL >> 6);
      heat_bump(pos + 4, CHARGE_FULL >> 8);
      if (pos > CELLS - 1) begin
        // pulse ran off the end: flash the tip and rearm
        travel      = '0;
        charge      = '0;
        heat[CELLS] = 8'hFF;
        boost       = 6'd32;
      end
    end

    b = (brt < 32) ? 0 : (brt >> 3);
    if (b > 255) b = 255;
    if (dim) b = b >> 2;
    flr = dim ? 16 : 63;
    if (b < flr) b = flr;
    drv = (b * int'(boost) + 8) >> 4;
    if (drv > 255) drv = 255;

    for (int k = 0; k < CELLS; k++) begin
      e.idx   = k[4:0];
      e.heat  = heat[k];
      e.tip   = heat[CELLS];
      e.drive = drv[7:0];
      e.last  = (k == CELLS - 1);
      cell_beats_due.push_back(e);
    end
  endtask

  task automatic check_cell_beat();
    cell_beat_t e;
    cell_beat_t got;
    got = '{out_tdata[4:0], out_tdata[12:5], out_tdata[20:13], out_tdata[28:21], out_tlast};
    if (cell_beats_due.size() == 0) begin
      n_bad++;
      if (n_bad <= 10)
        $display("%0t: unexpected beat idx=%0d heat=%0d tip=%0d drive=%0d last=%0b",
                 $realtime, got.idx, got.heat, got.tip, got.drive, got.last);
    end else begin
      e = cell_beats_due.pop_front();
      if (got.idx !== e.idx || got.heat !== e.heat || got.tip !== e.tip ||
          got.drive !== e.drive || got.last !== e.last) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: beat mismatch exp idx=%0d heat=%0d tip=%0d drive=%0d last=%0b",
                   $realtime, e.idx, e.heat, e.tip, e.drive, e.last,
                   " | got idx=%0d heat=%0d tip=%0d drive=%0d last=%0b",
                   got.idx, got.heat, got.tip, got.drive, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CELLS; i++)
        heat[i] = '0;
      charge = '0;
      travel = '0;
      boost  = 6'd16;
      dim    = 1'b0;
      n_bad  = 0;
      cell_beats_due.delete();
    end else begin
      if (cfg_wr_en)
        dim = cfg_wr_data;
      if (in_tvalid && in_tready)
        advance_heat_tick(in_tdata[10:0], in_tdata[21:11]);
      if (out_tvalid && out_tready)
        check_cell_beat();
    end
    n_due = cell_beats_due.size();
  end

endmodule

[sim/heat_pulse_led_animator_tb.sv]
// Top of the bench: clock, reset, tick stimulus, output back-pressure and the
// verdict. All prediction and comparison lives in hpla_beat_checker.
module heat_pulse_led_animator_tb;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic                       cfg_wr_data;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [hpla_pkg::IN_W-1:0]  in_tdata;    // throttle[10:0], brightness[21:11]
  logic                       out_tvalid;
  logic                       out_tready;
  logic [hpla_pkg::OUT_W-1:0] out_tdata;   // cell_index[4:0], cell_heat[12:5],
                                           // tip_heat[20:13], drive_level[28:21]
  logic                       out_tlast;

  int n_bad;
  int n_due;

  // percent chance per cycle that the sender idles / the receiver stalls
  int idle_pct    = 0;
  int stall_pct   = 0;
  // long receiver hold-off, counted down by the receiver process
  int hold_cycles = 0;

  heat_pulse_led_animator u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  hpla_beat_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .n_bad       (n_bad),
    .n_due       (n_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run, with the heaviest
  // stalls plus the hold-off.
  initial begin
    #1600000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: random stalls at stall_pct, or held low while a hold-off runs.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One tick beat. Called at a rising edge; returns at the edge where the
  // beat was taken, with tvalid still high so back-to-back beats need no gap.
  task automatic send_tick(input logic [10:0] thr, input logic [10:0] brt);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, brt, thr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering, let every expected beat come out, then let the back
  // end settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (n_due != 0);
    repeat (40) @(posedge clk);
  endtask

  // dim_level write; only called with the block idle
  task automatic write_dim(input logic v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [10:0] thr;
    logic [10:0] brt;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, full light: dead band edges of brightness, throttle extremes,
    // then flat-out throttle so the charge builds toward full.
    send_tick(11'd0,    11'd0);
    send_tick(11'd0,    11'd31);
    send_tick(11'd0,    11'd32);
    send_tick(11'd1,    11'd33);
    send_tick(11'd2047, 11'd2047);
    send_tick(11'd1024, 11'd1024);
    for (int n = 0; n < 8; n++)
      send_tick(11'd2047, 11'd504);
    drain();

    // Directed, low light: quartered brightness against the low floor.
    write_dim(1'b1);
    send_tick(11'd2047, 11'd0);
    send_tick(11'd2047, 11'd31);
    send_tick(11'd2047, 11'd32);
    send_tick(11'd2047, 11'd2047);
    send_tick(11'd2047, 11'd600);
    send_tick(11'd2047, 11'd1023);
    drain();

    // Random phases: no idling, sender idle, receiver stalls, both.
    // Throttle leans high so the pulse completes many laps (tip flash,
    // boost kick and relaxation, writes running past the tip).
    for (int ph = 0; ph < 4; ph++) begin
      write_dim(ph[0]);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < 72; n++) begin
        if ($urandom_range(99) < 70)
          thr = 11'($urandom_range(2047, 1400));
        else
          thr = 11'($urandom_range(2047, 0));
        if ($urandom_range(99) < 20)
          brt = 11'($urandom_range(40, 0));
        else
          brt = 11'($urandom_range(2047, 0));
        send_tick(thr, brt);
        // long output hold-off while ticks keep coming, to fill the queue
        if (ph == 0 && n == 20)
          hold_cycles = 300;
      end
      drain();
    end

    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/hpla_pkg.sv
hdl/hpla_front.sv
hdl/hpla_back.sv
hdl/heat_pulse_led_animator.sv
sim/hpla_beat_checker.sv
sim/heat_pulse_led_animator_tb.sv
